/* rtl/core/lfukv_pkg.sv */
package lfukv_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	localparam logic [4:0] MAX_ENTRIES_RST = 5'd16;

	typedef enum logic [2:0] {
		OP_LOOKUP      = 3'd0,
		OP_ADD         = 3'd1,
		OP_INVALIDATE  = 3'd2,
		OP_CLEAR       = 3'd3,
		OP_RESET_STATS = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_CLRHITS,
		ST_DONE
	} state_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

endpackage

/* rtl/core/lfukv_ram.sv */
module lfukv_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/lfu_associative_key_value_table.sv */
// LFU key/value table: up to ENTRIES entries kept as a gap-free ordered list in three
// small RAMs (keys, values, hit counts) that share one read address, walked one entry per
// cycle by a small sequencer around a single key/hit comparator. Lookup, add and
// invalidate take at most one pass over the valid entries; the least-hit victim for a
// replacing add is found during that same pass. Invalidate then moves the later entries
// down one per cycle, starting where the search stopped. Reset statistics walks the valid
// entries to zero their hit counts. Clear and unknown opcodes go straight to the done
// state. A new word is taken only once the previous one is finished; a finished result
// may still wait in the output register. There is no clearing pass after reset.
module lfu_associative_key_value_table
	import lfukv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_wr_en,
	input  logic [4:0]  cfg_wr_data,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [63:0] key,
	input  logic [63:0] value_in,

	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [63:0] value_out,
	output logic [4:0]  entry_count,
	output logic [31:0] lookup_total,
	output logic [31:0] hit_total,
	output logic [31:0] miss_total,
	output logic [31:0] invalidation_total
);

	state_t state_q, state_d;

	logic [4:0]       max_entries_q;
	op_t              op_q;
	logic [63:0]      key_q;
	logic [63:0]      val_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] ptr_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic [31:0]      min_hits_q;
	logic [IDX_W-1:0] min_idx_q;
	logic             found_q;
	logic [63:0]      vout_q;
	logic [31:0]      lookups_q;
	logic [31:0]      hits_q;
	logic [31:0]      misses_q;
	logic [31:0]      invals_q;
	logic             out_valid_q;

	// ram ports
	logic [IDX_W-1:0] raddr;
	logic [IDX_W-1:0] waddr;
	logic             key_we, val_we, hit_we;
	logic [63:0]      wkey, wval;
	logic [31:0]      whit;
	logic [63:0]      key_rd, val_rd;
	logic [31:0]      hit_rd;

	logic        in_acc;
	logic        more;
	logic        issue;
	logic        match;
	logic        scan_end;
	logic        shift_end;
	logic        out_load;
	logic        repl;
	logic        room;
	logic [31:0] max_ext;
	logic [31:0] lim;
	logic [31:0] cnt_ext;

	// effective limit: zero acts as one, clipped to the table size
	always_comb begin
		max_ext = 32'(max_entries_q);
		cnt_ext = 32'(count_q);
		if (max_ext == 32'd0) begin
			lim = 32'd1;
		end else if (max_ext > 32'(ENTRIES)) begin
			lim = 32'(ENTRIES);
		end else begin
			lim = max_ext;
		end
		repl = (cnt_ext >= lim) && (count_q != '0);
		room = cnt_ext < 32'(ENTRIES);
	end

	// control outputs
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		in_acc    = in_valid && (state_q == ST_IDLE);
		more      = ptr_q < count_q;
		match     = (state_q == ST_SCAN) && rd_vld_s1 && (key_rd == key_q);
		issue     = ((state_q == ST_SCAN) || (state_q == ST_SHIFT)) && more && !match;
		scan_end  = (state_q == ST_SCAN) && !match && !rd_vld_s1 && !more;
		shift_end = (state_q == ST_SHIFT) && !rd_vld_s1 && !more;
		out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
		raddr     = ptr_q[IDX_W-1:0];
		key_we    = 1'b0;
		val_we    = 1'b0;
		hit_we    = 1'b0;
		waddr     = rd_idx_s1;
		wkey      = key_q;
		wval      = val_q;
		whit      = 32'd0;
		case (state_q)
			ST_SCAN: begin
				if (match) begin
					if (op_q == OP_LOOKUP) begin
						hit_we = 1'b1;
						whit   = sat_inc(hit_rd);
					end else if (op_q == OP_ADD) begin
						val_we = 1'b1;
					end
				end else if (scan_end && (op_q == OP_ADD)) begin
					if (repl) begin
						key_we = 1'b1;
						val_we = 1'b1;
						hit_we = 1'b1;
						waddr  = min_idx_q;
					end else if (room) begin
						key_we = 1'b1;
						val_we = 1'b1;
						hit_we = 1'b1;
						waddr  = count_q[IDX_W-1:0];
					end
				end
			end
			ST_SHIFT: begin
				// move the entry just read one place down
				if (rd_vld_s1) begin
					key_we = 1'b1;
					val_we = 1'b1;
					hit_we = 1'b1;
					waddr  = IDX_W'(rd_idx_s1 - 1'b1);
					wkey   = key_rd;
					wval   = val_rd;
					whit   = hit_rd;
				end
			end
			ST_CLRHITS: begin
				if (more) begin
					hit_we = 1'b1;
					waddr  = ptr_q[IDX_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (op_t'(opcode))
						OP_LOOKUP, OP_ADD, OP_INVALIDATE: state_d = ST_SCAN;
						OP_RESET_STATS:                   state_d = ST_CLRHITS;
						default:                          state_d = ST_DONE;
					endcase
				end
			end
			ST_SCAN: begin
				if (match) begin
					state_d = (op_q == OP_INVALIDATE) ? ST_SHIFT : ST_DONE;
				end else if (scan_end) begin
					state_d = ST_DONE;
				end
			end
			ST_SHIFT: begin
				if (shift_end) begin
					state_d = ST_DONE;
				end
			end
			ST_CLRHITS: begin
				if (!more) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			max_entries_q <= MAX_ENTRIES_RST;
			count_q       <= '0;
			rd_vld_s1     <= 1'b0;
			lookups_q     <= '0;
			hits_q        <= '0;
			misses_q      <= '0;
			invals_q      <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				max_entries_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			rd_vld_s1 <= issue;
			if (in_acc) begin
				if (op_t'(opcode) == OP_CLEAR) begin
					count_q <= '0;
				end
				if (op_t'(opcode) == OP_RESET_STATS) begin
					lookups_q <= '0;
					hits_q    <= '0;
					misses_q  <= '0;
					invals_q  <= '0;
				end
			end
			if (match && (op_q == OP_LOOKUP)) begin
				lookups_q <= sat_inc(lookups_q);
				hits_q    <= sat_inc(hits_q);
			end
			if (scan_end && (op_q == OP_LOOKUP)) begin
				lookups_q <= sat_inc(lookups_q);
				misses_q  <= sat_inc(misses_q);
			end
			if (scan_end && (op_q == OP_ADD) && !repl && room) begin
				count_q <= count_q + 1'b1;
			end
			if (shift_end) begin
				count_q  <= count_q - 1'b1;
				invals_q <= sat_inc(invals_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q    <= op_t'(opcode);
			key_q   <= key;
			val_q   <= value_in;
			ptr_q   <= '0;
			found_q <= 1'b0;
			vout_q  <= '0;
		end
		if (issue || ((state_q == ST_CLRHITS) && more)) begin
			ptr_q <= ptr_q + 1'b1;
		end
		if (issue) begin
			rd_idx_s1 <= ptr_q[IDX_W-1:0];
		end
		// least-hit tracking, first smallest wins
		if ((state_q == ST_SCAN) && rd_vld_s1 && !match) begin
			if ((rd_idx_s1 == '0) || (hit_rd < min_hits_q)) begin
				min_hits_q <= hit_rd;
				min_idx_q  <= rd_idx_s1;
			end
		end
		if (match) begin
			if (op_q == OP_LOOKUP) begin
				found_q <= 1'b1;
				vout_q  <= val_rd;
			end else if (op_q == OP_INVALIDATE) begin
				ptr_q <= CNT_W'(rd_idx_s1) + 1'b1;
			end
		end
		if (shift_end) begin
			found_q <= 1'b1;
		end
		if (out_load) begin
			found              <= found_q;
			value_out          <= vout_q;
			entry_count        <= cnt_ext[4:0];
			lookup_total       <= lookups_q;
			hit_total          <= hits_q;
			miss_total         <= misses_q;
			invalidation_total <= invals_q;
		end
	end

	assign out_valid = out_valid_q;

	lfukv_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (waddr),
		.wdata (wkey),
		.raddr (raddr),
		.rdata (key_rd)
	);

	lfukv_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (waddr),
		.wdata (wval),
		.raddr (raddr),
		.rdata (val_rd)
	);

	lfukv_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_hit_ram (
		.clk   (clk),
		.we    (hit_we),
		.waddr (waddr),
		.wdata (whit),
		.raddr (raddr),
		.rdata (hit_rd)
	);

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(count_q) <= 32'(ENTRIES)))
		else $error("entry count beyond table size");

	a_hits_le_lookups: assert property (@(posedge clk) disable iff (!arst_n)
		(hits_q <= lookups_q) && (misses_q <= lookups_q))
		else $error("hit or miss total exceeds lookup total");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result shown without a finished operation");

	a_count_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q > $past(count_q)) |->
		((count_q == $past(count_q) + 1'b1) && ($past(op_q) == OP_ADD)))
		else $error("entry count grew other than by one add");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_IDLE) || (state_q == ST_DONE)) |-> !(key_we || val_we || hit_we))
		else $error("table written outside an operation");
`endif

endmodule
